// File: rtl/jsu_pkg.sv
// Shared types, codes and helpers for the JSON string unescape core.
// No dependencies; jsu_decode, the core and jsu_check import it.
package jsu_pkg;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_ESC,
        MODE_HEX1,
        MODE_WANT_BS,
        MODE_WANT_U,
        MODE_HEX2
    } mode_t;

    typedef enum logic [2:0] {
        RULE_NONE,
        RULE_GE_A0,
        RULE_LT_A0,
        RULE_GE_90,
        RULE_LT_90
    } rule_t;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam int unsigned MAX_RESULTS = 4;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6e;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;

    typedef struct packed {
        logic [1:0] pending;
        rule_t      rule;
        logic       err;
    } utf8_state_t;

    localparam utf8_state_t UTF8_CLEAR = '{pending: 2'd0, rule: RULE_NONE, err: 1'b0};

    typedef struct packed {
        logic [2:0]                         count;
        logic [MAX_RESULTS-1:0][1:0]        kind;
        logic [MAX_RESULTS-1:0][7:0]        data;
    } res_t;

    function automatic utf8_state_t utf8_step(utf8_state_t s, logic [7:0] b);
        utf8_state_t r;
        logic        ok;
        r  = s;
        ok = (b[7:6] == 2'b10);
        if (s.pending != 2'd0)
        begin
            case (s.rule)
                RULE_GE_A0: if (b < 8'ha0) ok = 1'b0;
                RULE_LT_A0: if (b >= 8'ha0) ok = 1'b0;
                RULE_GE_90: if (b < 8'h90) ok = 1'b0;
                RULE_LT_90: if (b >= 8'h90) ok = 1'b0;
                default: ;
            endcase
            r.rule = RULE_NONE;
            if (!ok)
            begin
                r.err     = 1'b1;
                r.pending = 2'd0;
            end
            else
            begin
                r.pending = s.pending - 2'd1;
            end
        end
        else if (b[7] == 1'b0)
        begin
            r = s;
        end
        else if (b inside {[8'hc2:8'hdf]})
        begin
            r.pending = 2'd1;
        end
        else if (b inside {[8'he0:8'hef]})
        begin
            r.pending = 2'd2;
            r.rule    = (b == 8'he0) ? RULE_GE_A0 : (b == 8'hed) ? RULE_LT_A0 : RULE_NONE;
        end
        else if (b inside {[8'hf0:8'hf4]})
        begin
            r.pending = 2'd3;
            r.rule    = (b == 8'hf0) ? RULE_GE_90 : (b == 8'hf4) ? RULE_LT_90 : RULE_NONE;
        end
        else
        begin
            r.err = 1'b1;
        end
        return r;
    endfunction

endpackage

// File: rtl/jsu_in_if.sv
// Byte request channel: raw JSON text byte plus start-of-string flag.
// Depends on nothing.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_req;

    modport source (output valid, output in_byte, output start_req, input ready);
    modport sink (input valid, input in_byte, input start_req, output ready);
endinterface

// File: rtl/jsu_out_if.sv
// Result request channel: kind, decoded byte and last-of-group flag.
// Depends on nothing.
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_kind, output out_byte, output last, input ready);
    modport sink (input valid, input out_kind, input out_byte, input last, output ready);
endinterface

// File: rtl/jsu_decode.sv
// Decoder state and single-pass decode of one byte into up to four results.
// Depends on jsu_pkg.
module jsu_decode
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  logic       start_req,
    output res_t       res
);

    typedef struct packed {
        logic [2:0]                  count;
        logic [MAX_RESULTS-1:0][7:0] data;
    } enc_t;

    mode_t       mode_reg, mode_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [15:0] hex_acc_reg, hex_acc_next;
    logic [9:0]  high_sur_reg, high_sur_next;
    utf8_state_t utf8_reg, utf8_next;

    function automatic logic [4:0] hex_value(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
            r = {1'b1, c[3:0]};
        else if ((c inside {[8'h61:8'h66]}) || (c inside {[8'h41:8'h46]}))
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        return r;
    endfunction

    function automatic enc_t encode(logic [20:0] v);
        enc_t e;
        e = '0;
        if (v <= 21'h7f)
        begin
            e.count   = 3'd1;
            e.data[0] = v[7:0];
        end
        else if (v <= 21'h7ff)
        begin
            e.count   = 3'd2;
            e.data[0] = {3'b110, v[10:6]};
            e.data[1] = {2'b10, v[5:0]};
        end
        else if (v <= 21'hffff)
        begin
            e.count   = 3'd3;
            e.data[0] = {4'b1110, v[15:12]};
            e.data[1] = {2'b10, v[11:6]};
            e.data[2] = {2'b10, v[5:0]};
        end
        else
        begin
            e.count   = 3'd4;
            e.data[0] = {5'b11110, v[20:18]};
            e.data[1] = {2'b10, v[17:12]};
            e.data[2] = {2'b10, v[11:6]};
            e.data[3] = {2'b10, v[5:0]};
        end
        return e;
    endfunction

    always_comb
    begin
        logic [4:0]  hv;
        enc_t        enc;
        logic        use_enc;
        logic [20:0] cp;
        mode_next     = mode_reg;
        hex_cnt_next  = hex_cnt_reg;
        hex_acc_next  = hex_acc_reg;
        high_sur_next = high_sur_reg;
        utf8_next     = utf8_reg;
        res           = '0;
        hv            = 5'd0;
        enc           = '0;
        use_enc       = 1'b0;
        cp            = 21'd0;

        if (start_req)
        begin
            hex_cnt_next  = 2'd0;
            hex_acc_next  = 16'd0;
            high_sur_next = 10'd0;
            utf8_next     = UTF8_CLEAR;
            if (in_byte == CH_QUOTE)
            begin
                mode_next = MODE_STR;
            end
            else
            begin
                res.count   = 3'd1;
                res.kind[0] = KIND_ERR;
                mode_next   = MODE_IDLE;
            end
        end
        else
        begin
            case (mode_reg)
                MODE_STR:
                begin
                    if (in_byte == CH_QUOTE)
                    begin
                        res.count   = 3'd1;
                        res.kind[0] = (utf8_reg.err || utf8_reg.pending != 2'd0) ?
                                      KIND_ERR : KIND_OK;
                        mode_next   = MODE_IDLE;
                    end
                    else if (in_byte < CH_SPACE)
                    begin
                        res.count   = 3'd1;
                        res.kind[0] = KIND_ERR;
                        mode_next   = MODE_IDLE;
                    end
                    else if (in_byte == CH_BSLASH)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        res.count   = 3'd1;
                        res.kind[0] = KIND_DATA;
                        res.data[0] = in_byte;
                    end
                end
                MODE_ESC:
                begin
                    mode_next   = MODE_STR;
                    res.count   = 3'd1;
                    res.kind[0] = KIND_DATA;
                    case (in_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: res.data[0] = in_byte;
                        CH_B: res.data[0] = 8'h08;
                        CH_F: res.data[0] = 8'h0c;
                        CH_N: res.data[0] = 8'h0a;
                        CH_R: res.data[0] = 8'h0d;
                        CH_T: res.data[0] = 8'h09;
                        CH_U:
                        begin
                            res.count    = 3'd0;
                            hex_cnt_next = 2'd0;
                            hex_acc_next = 16'd0;
                            mode_next    = MODE_HEX1;
                        end
                        default:
                        begin
                            res.kind[0] = KIND_ERR;
                            mode_next   = MODE_IDLE;
                        end
                    endcase
                end
                MODE_HEX1, MODE_HEX2:
                begin
                    hv = hex_value(in_byte);
                    if (!hv[4])
                    begin
                        res.count   = 3'd1;
                        res.kind[0] = KIND_ERR;
                        mode_next   = MODE_IDLE;
                    end
                    else
                    begin
                        hex_acc_next = {hex_acc_reg[11:0], hv[3:0]};
                        if (hex_cnt_reg != 2'd3)
                        begin
                            hex_cnt_next = hex_cnt_reg + 2'd1;
                        end
                        else
                        begin
                            hex_cnt_next = 2'd0;
                            if (mode_reg == MODE_HEX1)
                            begin
                                if (hex_acc_next inside {[16'hd800:16'hdbff]})
                                begin
                                    high_sur_next = hex_acc_next[9:0];
                                    mode_next     = MODE_WANT_BS;
                                end
                                else if (hex_acc_next inside {[16'hdc00:16'hdfff]})
                                begin
                                    res.count   = 3'd1;
                                    res.kind[0] = KIND_ERR;
                                    mode_next   = MODE_IDLE;
                                end
                                else
                                begin
                                    mode_next = MODE_STR;
                                    cp        = {5'd0, hex_acc_next};
                                    use_enc   = 1'b1;
                                end
                            end
                            else if (hex_acc_next inside {[16'hdc00:16'hdfff]})
                            begin
                                mode_next = MODE_STR;
                                cp        = 21'h10000 + {1'b0, high_sur_reg, hex_acc_next[9:0]};
                                use_enc   = 1'b1;
                            end
                            else
                            begin
                                res.count   = 3'd1;
                                res.kind[0] = KIND_ERR;
                                mode_next   = MODE_IDLE;
                            end
                        end
                    end
                end
                MODE_WANT_BS:
                begin
                    if (in_byte == CH_BSLASH)
                    begin
                        mode_next = MODE_WANT_U;
                    end
                    else
                    begin
                        res.count   = 3'd1;
                        res.kind[0] = KIND_ERR;
                        mode_next   = MODE_IDLE;
                    end
                end
                MODE_WANT_U:
                begin
                    if (in_byte == CH_U)
                    begin
                        hex_cnt_next = 2'd0;
                        hex_acc_next = 16'd0;
                        mode_next    = MODE_HEX2;
                    end
                    else
                    begin
                        res.count   = 3'd1;
                        res.kind[0] = KIND_ERR;
                        mode_next   = MODE_IDLE;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end

        if (use_enc)
        begin
            enc       = encode(cp);
            res.count = enc.count;
            res.kind  = '0;
            res.data  = enc.data;
        end

        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if ((3'(i) < res.count) && (res.kind[i] == KIND_DATA))
                utf8_next = utf8_step(utf8_next, res.data[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            hex_cnt_reg  <= 2'd0;
            hex_acc_reg  <= 16'd0;
            high_sur_reg <= 10'd0;
            utf8_reg     <= UTF8_CLEAR;
        end
        else if (step)
        begin
            mode_reg     <= mode_next;
            hex_cnt_reg  <= hex_cnt_next;
            hex_acc_reg  <= hex_acc_next;
            high_sur_reg <= high_sur_next;
            utf8_reg     <= utf8_next;
        end
    end

endmodule

// File: rtl/json_string_unescape_utf8_check_core.sv
// Path: a byte is registered in the input stage, decoded combinationally, and its results are
// registered in the four-entry result buffer, which drains one result per cycle while ready.
// Throughput: one byte per cycle while each byte yields at most one result and result.ready is
// high; a byte with more results holds the next byte in the input stage until its last is taken.
// Reset (rst_n low, async): decoder goes idle awaiting a start, input and result stages empty.
module json_string_unescape_utf8_check_core
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    jsu_in_if.sink     text,
    jsu_out_if.source  result
);

    logic                        s1_valid_reg;
    logic [7:0]                  s1_byte_reg;
    logic                        s1_start_reg;
    logic [2:0]                  cnt_reg;
    logic [1:0]                  pos_reg;
    logic [MAX_RESULTS-1:0][1:0] kind_reg;
    logic [MAX_RESULTS-1:0][7:0] byte_reg;
    logic                        buf_free;
    logic                        step;
    logic                        load;
    logic                        pop;
    res_t                        res;

    jsu_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .in_byte   (s1_byte_reg),
        .start_req (s1_start_reg),
        .res       (res)
    );

    always_comb
    begin
        pop          = (cnt_reg != 3'd0) && result.ready;
        buf_free     = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && result.ready);
        step         = s1_valid_reg && buf_free;
        load         = step && (res.count != 3'd0);
        text.ready   = !s1_valid_reg || buf_free;
        result.valid = (cnt_reg != 3'd0);
        result.out_kind = kind_reg[pos_reg];
        result.out_byte = byte_reg[pos_reg];
        result.last  = (cnt_reg == 3'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            cnt_reg      <= 3'd0;
            pos_reg      <= 2'd0;
        end
        else
        begin
            if (text.valid && text.ready)
                s1_valid_reg <= 1'b1;
            else if (step)
                s1_valid_reg <= 1'b0;

            if (load)
            begin
                cnt_reg <= res.count;
                pos_reg <= 2'd0;
            end
            else if (pop)
            begin
                cnt_reg <= cnt_reg - 3'd1;
                pos_reg <= pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            s1_byte_reg  <= text.in_byte;
            s1_start_reg <= text.start_req;
        end
        if (load)
        begin
            kind_reg <= res.kind;
            byte_reg <= res.data;
        end
    end

endmodule

// File: rtl/jsu_check.sv
// Port-level assertions for the JSON string unescape core, bound to the top level.
// Depends on jsu_pkg and json_string_unescape_utf8_check_core.
module jsu_check
    import jsu_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       text_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic [1:0] result_kind,
    input logic [7:0] result_byte,
    input logic       result_last
);

    a_stall_means_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !text_ready |-> result_valid)
        else $error("input stalled with no result pending");

    a_status_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind != KIND_DATA) |-> (result_byte == 8'd0))
        else $error("status result carries a nonzero byte");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind != KIND_DATA) |-> result_last)
        else $error("status result not marked last");

    a_group_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && !result_last) |=> result_valid)
        else $error("gap inside a result group");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
        (result_valid && $stable(result_kind) && $stable(result_byte) && $stable(result_last)))
        else $error("stalled result changed");

endmodule

bind json_string_unescape_utf8_check_core jsu_check u_jsu_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .text_ready   (text.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_kind  (result.out_kind),
    .result_byte  (result.out_byte),
    .result_last  (result.last)
);
